@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers that drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants of the stereo chorus delay.
// ----------------------------------------------------------------------------
package scd_pkg;
	localparam int unsigned CFG_IDX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 32;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PHASE_STEP  = 3'd0,
		REG_BASE_DELAY  = 3'd1,
		REG_DEPTH_DELAY = 3'd2,
		REG_DRY_GAIN    = 3'd3,
		REG_WET_GAIN    = 3'd4
	} reg_idx_t;

	localparam logic [31:0] PHASE_STEP_RST  = 32'd26844;
	localparam logic [17:0] BASE_DELAY_RST  = 18'd86016;
	localparam logic [15:0] DEPTH_DELAY_RST = 16'd53760;
	localparam logic [15:0] DRY_GAIN_RST    = 16'd27779;
	localparam logic [15:0] WET_GAIN_RST    = 16'd17364;

	typedef struct packed {
		logic [31:0] phase_step;
		logic [17:0] base_delay;
		logic [15:0] depth_delay;
		logic [15:0] dry_gain;
		logic [15:0] wet_gain;
	} cfg_t;
endpackage

@@ design/scd_line.sv @@
// ----------------------------------------------------------------------------
// scd_line
// One delay line: single-port synchronous memory; the clearing sweep is driven from the top.
// ----------------------------------------------------------------------------
module scd_line #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned SW    = 24
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [SW-1:0]            wdata,
	output logic [SW-1:0]            rdata
);
	logic [SW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ design/stereo_chorus_delay_top.sv @@
// ----------------------------------------------------------------------------
// stereo_chorus_delay_top
// Stereo chorus: modulated delay per channel, cubic Hermite interpolation,
// dry/wet mix with saturation.
// ----------------------------------------------------------------------------
// channel | direction | handshake        | content
// s_axis  | in        | tvalid/tready    | left_in, right_in
// m_axis  | out       | tvalid/tready    | left_out, right_out
// cfg     | in        | cfg_we           | register index and data
//
// Each stereo pair is first written to both lines in the write state; then,
// per channel, an address state, reads of the four taps through the single
// memory port, the Hermite steps and a mixing state produce the result. A new
// pair is accepted only in the idle state, once the previous pair is through.
// After reset a clearing sweep zeros all LINE_DEPTH entries of both lines; no
// input transaction is taken meanwhile. A result waits in the output register;
// the right-channel mix holds while that register is full and not being taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_chorus_delay_top #(
	parameter int unsigned LINE_DEPTH  = 1024,
	parameter int unsigned SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [SAMPLE_BITS-1:0] left_in, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_in
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [SAMPLE_BITS-1:0] left_out, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_out
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [scd_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  logic [scd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	localparam int unsigned AW = $clog2(LINE_DEPTH);
	localparam int unsigned SW = SAMPLE_BITS;
	localparam int unsigned TW = ((2*SAMPLE_BITS+7)/8)*8;
	localparam int unsigned PW = AW + 8;          // Q.8 position width
	localparam int unsigned WW = SW + 40;         // interpolation width
	localparam int unsigned DLY_W = (PW + 2 > 20) ? PW + 2 : 20;
	localparam logic [PW:0] HI_DELAY = PW'(LINE_DEPTH - 2) << 8;
	localparam logic signed [WW+2:0] SAT_HI = $signed({{(WW+4-SW){1'b0}}, {(SW-1){1'b1}}});
	localparam logic signed [WW+2:0] SAT_LO = $signed({{(WW+4-SW){1'b1}}, {(SW-1){1'b0}}});

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_WRITE = 7'b0000100,
		ST_ADDR  = 7'b0001000,
		ST_READ  = 7'b0010000,
		ST_CALC  = 7'b0100000,
		ST_MIX   = 7'b1000000
	} state_t;

	state_t state_q;
	scd_pkg::cfg_t cfg_q;
	logic [AW-1:0] wr_idx_q, clr_q, rd_addr_q, tap_addr;
	logic [31:0] phase_q;
	logic [SW-1:0] dry_l_q, dry_r_q;
	logic chan_q;                // 0 left, 1 right
	logic [2:0] tap_q;           // tap counter, then Hermite step counter
	logic [7:0] frac_q;
	logic signed [SW-1:0] y_q [4];
	logic signed [SW-1:0] out_l_q, out_r_q, mix_l_q;
	logic out_valid_q;
	logic signed [WW-1:0] wet_q, acc_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step  <= scd_pkg::PHASE_STEP_RST;
			cfg_q.base_delay  <= scd_pkg::BASE_DELAY_RST;
			cfg_q.depth_delay <= scd_pkg::DEPTH_DELAY_RST;
			cfg_q.dry_gain    <= scd_pkg::DRY_GAIN_RST;
			cfg_q.wet_gain    <= scd_pkg::WET_GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				scd_pkg::REG_PHASE_STEP:  cfg_q.phase_step  <= cfg_data;
				scd_pkg::REG_BASE_DELAY:  cfg_q.base_delay  <= cfg_data[17:0];
				scd_pkg::REG_DEPTH_DELAY: cfg_q.depth_delay <= cfg_data[15:0];
				scd_pkg::REG_DRY_GAIN:    cfg_q.dry_gain    <= cfg_data[15:0];
				scd_pkg::REG_WET_GAIN:    cfg_q.wet_gain    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// delay computation for the current channel (combinational, one multiply)
	logic [31:0] ch_phase, tri_d;
	logic [47:0] mod_prod;
	logic signed [DLY_W-1:0] delay_raw;
	logic [PW:0] delay_c;
	logic signed [PW+1:0] rp;
	always_comb begin
		ch_phase  = phase_q + {chan_q, 31'd0};
		tri_d     = ch_phase[31] ? {1'b0, ch_phase[30:0]} : 32'h8000_0000 - ch_phase;
		mod_prod  = 48'(cfg_q.depth_delay) * 48'(tri_d) + 48'h2000_0000;
		delay_raw = DLY_W'(cfg_q.base_delay) + DLY_W'(mod_prod[47:30])
			- DLY_W'(cfg_q.depth_delay);
		if (delay_raw > $signed(DLY_W'(HI_DELAY))) delay_c = HI_DELAY;
		else if (delay_raw < $signed(DLY_W'(256))) delay_c = (PW+1)'(256);
		else delay_c = (PW+1)'(delay_raw);
		rp = $signed({2'b0, wr_idx_q, 8'd0}) - $signed({1'b0, delay_c});
		if (rp < 0) rp = rp + $signed((PW+2)'(LINE_DEPTH) << 8);
	end

	// memory addressing
	logic we_mem;
	logic [SW-1:0] wd_l, wd_r, rd_l, rd_r;
	always_comb begin
		we_mem = 1'b0;
		wd_l = dry_l_q;
		wd_r = dry_r_q;
		tap_addr = rd_addr_q;
		case (state_q)
			ST_CLEAR: begin
				we_mem = 1'b1; wd_l = '0; wd_r = '0; tap_addr = clr_q;
			end
			ST_WRITE: begin
				we_mem = 1'b1; tap_addr = wr_idx_q;
			end
			default: ;
		endcase
	end

	scd_line #(.DEPTH(LINE_DEPTH), .SW(SW)) u_left (
		.clk(clk), .we(we_mem), .addr(tap_addr), .wdata(wd_l), .rdata(rd_l));
	scd_line #(.DEPTH(LINE_DEPTH), .SW(SW)) u_right (
		.clk(clk), .we(we_mem), .addr(tap_addr), .wdata(wd_r), .rdata(rd_r));

	// Hermite by Horner, one step a cycle:
	// acc = ((e*f + c*256)*f + b*65536)*f + a*2^24, wet = (acc+2^24)>>>25
	logic signed [SW+3:0] ca, cb, cc, ce;
	logic signed [WW-1:0] horner;
	logic signed [8:0] fs;
	always_comb begin
		fs  = $signed({1'b0, frac_q});
		ca  = (SW+4)'(2 * y_q[1]);
		cb  = (SW+4)'(y_q[2]) - (SW+4)'(y_q[0]);
		cc  = 2*(SW+4)'(y_q[0]) - 5*(SW+4)'(y_q[1]) + 4*(SW+4)'(y_q[2]) - (SW+4)'(y_q[3]);
		ce  = (SW+4)'(y_q[3]) - (SW+4)'(y_q[0]) + 3*((SW+4)'(y_q[1]) - (SW+4)'(y_q[2]));
		case (tap_q[1:0])
			2'd0: horner = WW'(ce) * WW'(fs) + (WW'(cc) <<< 8);
			2'd1: horner = acc_q * WW'(fs) + (WW'(cb) <<< 16);
			default: horner = acc_q * WW'(fs) + (WW'(ca) <<< 24);
		endcase
	end

	// mix and saturate
	logic signed [SW-1:0] dry_sel;
	logic signed [WW+17:0] mix;
	logic signed [WW+2:0] mixs;
	logic signed [SW-1:0] sat;
	always_comb begin
		dry_sel = chan_q ? dry_r_q : dry_l_q;
		mix = (WW+18)'(dry_sel) * $signed({2'b0, cfg_q.dry_gain})
			+ (WW+18)'(wet_q) * $signed({2'b0, cfg_q.wet_gain}) + (WW+18)'(1 << 14);
		mixs = (WW+3)'(mix >>> 15);
		if (mixs > SAT_HI) sat = {1'b0, {(SW-1){1'b1}}};
		else if (mixs < SAT_LO) sat = {1'b1, {(SW-1){1'b0}}};
		else sat = SW'(mixs);
	end

	wire in_fire  = s_axis_tvalid && s_axis_tready;
	wire out_fire = m_axis_tvalid && m_axis_tready;
	// load the output register once it is free or being taken
	wire load_out = (state_q == ST_MIX) && chan_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = (state_q == ST_IDLE);

	// sequencer: write both lines, then per channel read four taps, interpolate, mix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			wr_idx_q <= '0;
			phase_q <= '0;
			chan_q <= 1'b0;
			tap_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (out_fire) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(LINE_DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_fire) state_q <= ST_WRITE;
				ST_WRITE: begin
					chan_q <= 1'b0;
					state_q <= ST_ADDR;
				end
				ST_ADDR: begin
					// first tap sits one sample before p0, wrapping at the line end
					rd_addr_q <= (rp[PW-1:8] == AW'(0)) ? AW'(LINE_DEPTH - 1)
						: rp[PW-1:8] - AW'(1);
					frac_q <= rp[7:0];
					tap_q <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					// advance the tap address; capture the previous tap's data
					if (tap_q != 3'd0) y_q[tap_q[1:0] - 2'd1] <= chan_q ? rd_r : rd_l;
					if (tap_q == 3'd4) begin
						tap_q <= '0;
						state_q <= ST_CALC;
					end else begin
						tap_q <= tap_q + 3'd1;
						rd_addr_q <= (rd_addr_q == AW'(LINE_DEPTH - 1)) ? '0
							: rd_addr_q + AW'(1);
					end
				end
				ST_CALC: begin
					if (tap_q == 3'd3) begin
						wet_q <= (acc_q + (WW'(1) <<< 24)) >>> 25;
						state_q <= ST_MIX;
					end else begin
						acc_q <= horner;
						tap_q <= tap_q + 3'd1;
					end
				end
				ST_MIX: begin
					if (!chan_q) begin
						mix_l_q <= sat;
						chan_q <= 1'b1;
						state_q <= ST_ADDR;
					end else if (load_out) begin
						out_l_q <= mix_l_q;
						out_r_q <= sat;
						wr_idx_q <= (wr_idx_q == AW'(LINE_DEPTH - 1)) ? '0
							: wr_idx_q + AW'(1);
						phase_q <= phase_q + cfg_q.phase_step;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the input pair as the dry samples
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dry_l_q <= s_axis_tdata[SW-1:0];
			dry_r_q <= s_axis_tdata[2*SW-1:SW];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TW'({out_r_q, out_l_q});

	`ASSERT_IMPLIES(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !s_axis_tready)
	`ASSERT_NEXT(a_accept_to_write, clk, arst_n, in_fire, state_q == ST_WRITE)
	`ASSERT_NEXT(a_hold_result, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
